>>> rtl/format_spec_parser_macros.svh
// assertion helpers for the format spec parser
`ifndef FORMAT_SPEC_PARSER_MACROS_SVH
`define FORMAT_SPEC_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define FSP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define FSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/fsp_pkg.sv
`default_nettype none

package fsp_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_BEGIN  = 3'd0,
      PH_FLAGS  = 3'd1,
      PH_SEP    = 3'd2,
      PH_ARGIDX = 3'd3,
      PH_WIDTH  = 3'd4,
      PH_PREC   = 3'd5,
      PH_MOD    = 3'd6,
      PH_IDLE   = 3'd7
   } phase_type;

   // outcome of one character
   typedef enum logic [1:0] {
      RES_MORE = 2'd0,
      RES_DONE = 2'd1,
      RES_ERR  = 2'd2
   } res_type;

   localparam logic [6:0]  MAX_SPEC_LEN = 7'd127;
   localparam logic [6:0]  MAX_DIGITS   = 7'd63;
   localparam logic [6:0]  CNT_SAT      = 7'd127;
   localparam logic [7:0]  ARG_MAX      = 8'd255;
   localparam logic [15:0] NUM_MAX      = 16'hFFFF;
   localparam logic [1:0]  MAX_MODS     = 2'd3;

   // mark bit positions
   localparam int MK_SPACE = 0;
   localparam int MK_ZERO  = 1;
   localparam int MK_HASH  = 2;
   localparam int MK_MINUS = 3;
   localparam int MK_PLUS  = 4;
   localparam int MK_QUOTE = 5;
   localparam int MK_BOOL  = 6;
   localparam int MK_VIDX  = 7;
   localparam int MK_WIDTH = 8;
   localparam int MK_WSTAR = 9;
   localparam int MK_WIDX  = 10;
   localparam int MK_PREC  = 11;
   localparam int MK_PSTAR = 12;
   localparam int MK_PIDX  = 13;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_D0     = 8'h30;
   localparam logic [7:0] CH_D1     = 8'h31;
   localparam logic [7:0] CH_D9     = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_UP_L   = 8'h4C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LO_B   = 8'h62;
   localparam logic [7:0] CH_LO_H   = 8'h68;
   localparam logic [7:0] CH_LO_J   = 8'h6A;
   localparam logic [7:0] CH_LO_L   = 8'h6C;
   localparam logic [7:0] CH_LO_Q   = 8'h71;
   localparam logic [7:0] CH_LO_T   = 8'h74;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

   typedef struct packed {
      phase_type        phase;
      logic             num_active;
      logic [15:0]      num_accum;
      logic [6:0]       digit_cnt;
      logic [6:0]       position;
      logic [7:0]       arg_cnt;
      logic [13:0]      marks;
      logic [7:0]       sep;
      logic [15:0]      width_val;
      logic [15:0]      prec_val;
      logic [7:0]       vidx;
      logic [7:0]       widx;
      logic [7:0]       pidx;
      logic [2:0][7:0]  mods;
      logic [1:0]       mod_cnt;
   } state_type;

   typedef struct packed {
      logic        status;
      logic [13:0] marks;
      logic [7:0]  separator;
      logic [15:0] width_value;
      logic [15:0] precision_value;
      logic [7:0]  value_index;
      logic [7:0]  width_index;
      logic [7:0]  precision_index;
      logic [23:0] modifiers;
      logic [7:0]  conversion;
      logic [6:0]  spec_length;
      logic [8:0]  arg_next;
   } result_type;

   // decimal accumulate with saturation, acc*10 as shift-add
   function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
      logic [19:0] v;
      v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, c[3:0]};
      return (v > {4'd0, NUM_MAX}) ? NUM_MAX : v[15:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/fsp_step.sv
`default_nettype none

// one character through the parser, pure combinational
module fsp_step (
   input  wire  fsp_pkg::state_type  st,
   input  wire  logic [7:0]          ch,
   input  wire  logic                first,
   input  wire  logic [7:0]          arg_base,
   input  wire  logic                bool_en,
   output fsp_pkg::state_type        st_next,
   output logic                      emit,
   output fsp_pkg::result_type       result
);

   fsp_pkg::state_type pre;
   fsp_pkg::state_type nx;
   fsp_pkg::res_type   res;
   logic               fin;
   logic               live;
   logic               is_dig;
   logic               is_nz;
   logic [15:0]        acc_add;
   logic [6:0]         cnt_add;
   logic               idx_ok;

   // restart or continue
   always_comb begin
      pre = st;
      if (first) begin
         pre         = '0;
         pre.phase   = fsp_pkg::PH_BEGIN;
         pre.arg_cnt = arg_base;
      end
      pre.position = pre.position + 7'd1;
   end

   assign live    = first || (st.phase != fsp_pkg::PH_IDLE);
   assign is_dig  = (ch >= fsp_pkg::CH_D0) && (ch <= fsp_pkg::CH_D9);
   assign is_nz   = (ch >= fsp_pkg::CH_D1) && (ch <= fsp_pkg::CH_D9);
   assign acc_add = fsp_pkg::acc_digit(pre.num_accum, ch);
   assign cnt_add = (pre.digit_cnt < fsp_pkg::CNT_SAT) ? pre.digit_cnt + 7'd1 : pre.digit_cnt;
   assign idx_ok  = (pre.digit_cnt <= fsp_pkg::MAX_DIGITS) && (pre.num_accum != 16'd0)
                    && (pre.num_accum <= {8'd0, fsp_pkg::ARG_MAX});

   always_comb begin
      nx  = pre;
      fin = 1'b0;
      res = fsp_pkg::RES_MORE;

      if ((ch == fsp_pkg::CH_NUL) || (pre.position >= fsp_pkg::MAX_SPEC_LEN)) begin
         fin = 1'b1;
         res = fsp_pkg::RES_ERR;
      end

      // optional leading value index
      if (!fin && nx.phase == fsp_pkg::PH_BEGIN) begin
         nx.num_active = 1'b0;
         if (is_nz) begin
            nx.num_active = 1'b1;
            nx.num_accum  = {12'd0, ch[3:0]};
            nx.digit_cnt  = 7'd1;
            nx.phase      = fsp_pkg::PH_ARGIDX;
            fin           = 1'b1;
         end else begin
            nx.phase = fsp_pkg::PH_FLAGS;
         end
      end

      if (!fin && nx.phase == fsp_pkg::PH_FLAGS) begin
         fin = 1'b1;
         case (ch)
            fsp_pkg::CH_SPACE: nx.marks[fsp_pkg::MK_SPACE] = 1'b1;
            fsp_pkg::CH_D0:    nx.marks[fsp_pkg::MK_ZERO]  = 1'b1;
            fsp_pkg::CH_HASH:  nx.marks[fsp_pkg::MK_HASH]  = 1'b1;
            fsp_pkg::CH_MINUS: nx.marks[fsp_pkg::MK_MINUS] = 1'b1;
            fsp_pkg::CH_PLUS:  nx.marks[fsp_pkg::MK_PLUS]  = 1'b1;
            fsp_pkg::CH_QUOTE: nx.marks[fsp_pkg::MK_QUOTE] = 1'b1;
            fsp_pkg::CH_LO_B: begin
               if (bool_en) nx.marks[fsp_pkg::MK_BOOL] = 1'b1;
               else fin = 1'b0;
            end
            default: fin = 1'b0;
         endcase
         if (!fin) nx.phase = fsp_pkg::PH_SEP;
      end

      if (!fin && nx.phase == fsp_pkg::PH_SEP) begin
         nx.phase = fsp_pkg::PH_WIDTH;
         if (ch inside {fsp_pkg::CH_COMMA, fsp_pkg::CH_SEMI, fsp_pkg::CH_COLON,
                        fsp_pkg::CH_UNDER}) begin
            nx.sep = ch;
            fin    = 1'b1;
         end
      end

      if (!fin && nx.phase == fsp_pkg::PH_ARGIDX) begin
         if (is_dig) begin
            nx.num_accum = acc_add;
            nx.digit_cnt = cnt_add;
            fin          = 1'b1;
         end else if (ch == fsp_pkg::CH_DOLLAR) begin
            fin = 1'b1;
            if (!idx_ok) begin
               res = fsp_pkg::RES_ERR;
            end else begin
               nx.vidx                     = pre.num_accum[7:0];
               nx.marks[fsp_pkg::MK_VIDX]  = 1'b1;
               nx.num_active               = 1'b0;
               nx.arg_cnt                  = pre.num_accum[7:0];
               nx.phase                    = fsp_pkg::PH_FLAGS;
            end
         end else begin
            nx.phase = fsp_pkg::PH_WIDTH;
         end
      end

      if (!fin && nx.phase == fsp_pkg::PH_WIDTH) begin
         if (!nx.num_active) begin
            if (ch == fsp_pkg::CH_STAR) begin
               nx.marks[fsp_pkg::MK_WIDTH] = 1'b1;
               nx.marks[fsp_pkg::MK_WSTAR] = 1'b1;
               nx.num_active               = 1'b1;
               nx.num_accum                = 16'd0;
               nx.digit_cnt                = 7'd0;
               fin                         = 1'b1;
            end else if (is_nz) begin
               nx.marks[fsp_pkg::MK_WIDTH] = 1'b1;
               nx.num_active               = 1'b1;
               nx.num_accum                = {12'd0, ch[3:0]};
               nx.digit_cnt                = 7'd1;
               fin                         = 1'b1;
            end
         end else if (is_dig) begin
            nx.num_accum = acc_add;
            nx.digit_cnt = cnt_add;
            fin          = 1'b1;
         end else if (ch == fsp_pkg::CH_DOLLAR) begin
            fin = 1'b1;
            if (!nx.marks[fsp_pkg::MK_WSTAR] || !idx_ok) begin
               res = fsp_pkg::RES_ERR;
            end else begin
               nx.widx                     = pre.num_accum[7:0];
               nx.marks[fsp_pkg::MK_WIDX]  = 1'b1;
               nx.num_active               = 1'b0;
               nx.arg_cnt                  = pre.num_accum[7:0];
               nx.phase                    = fsp_pkg::PH_PREC;
            end
         end else if (!nx.marks[fsp_pkg::MK_WSTAR]) begin
            if (nx.digit_cnt > fsp_pkg::MAX_DIGITS) begin
               fin = 1'b1;
               res = fsp_pkg::RES_ERR;
            end else begin
               nx.width_val                = nx.num_accum;
               nx.marks[fsp_pkg::MK_WIDTH] = 1'b1;
            end
         end else begin
            if (nx.digit_cnt != 7'd0) begin
               fin = 1'b1;
               res = fsp_pkg::RES_ERR;
            end else if (nx.arg_cnt < fsp_pkg::ARG_MAX) begin
               nx.arg_cnt = nx.arg_cnt + 8'd1;
            end
         end
         if (!fin) begin
            nx.num_active = 1'b0;
            nx.phase      = fsp_pkg::PH_PREC;
         end
      end

      if (!fin && nx.phase == fsp_pkg::PH_PREC) begin
         if (!nx.num_active) begin
            if (ch == fsp_pkg::CH_DOT) begin
               nx.marks[fsp_pkg::MK_PREC] = 1'b1;
               nx.num_active              = 1'b1;
               nx.num_accum               = 16'd0;
               nx.digit_cnt               = 7'd0;
               fin                        = 1'b1;
            end
         end else if (ch == fsp_pkg::CH_STAR) begin
            fin = 1'b1;
            if (nx.marks[fsp_pkg::MK_PSTAR]) begin
               res = fsp_pkg::RES_ERR;
            end else begin
               nx.marks[fsp_pkg::MK_PSTAR] = 1'b1;
               nx.num_accum                = 16'd0;
               nx.digit_cnt                = 7'd0;
            end
         end else if (is_dig) begin
            nx.num_accum = acc_add;
            nx.digit_cnt = cnt_add;
            fin          = 1'b1;
         end else if (ch == fsp_pkg::CH_DOLLAR) begin
            fin = 1'b1;
            if (!nx.marks[fsp_pkg::MK_PSTAR] || !idx_ok) begin
               res = fsp_pkg::RES_ERR;
            end else begin
               nx.pidx                     = pre.num_accum[7:0];
               nx.marks[fsp_pkg::MK_PIDX]  = 1'b1;
               nx.num_active               = 1'b0;
               nx.arg_cnt                  = pre.num_accum[7:0];
               nx.phase                    = fsp_pkg::PH_MOD;
            end
         end else if (!nx.marks[fsp_pkg::MK_PSTAR]) begin
            if (nx.digit_cnt > fsp_pkg::MAX_DIGITS) begin
               fin = 1'b1;
               res = fsp_pkg::RES_ERR;
            end else begin
               nx.prec_val = nx.num_accum;
            end
         end else begin
            if (nx.digit_cnt != 7'd0) begin
               fin = 1'b1;
               res = fsp_pkg::RES_ERR;
            end else if (nx.arg_cnt < fsp_pkg::ARG_MAX) begin
               nx.arg_cnt = nx.arg_cnt + 8'd1;
            end
         end
         if (!fin) begin
            nx.num_active = 1'b0;
            nx.phase      = fsp_pkg::PH_MOD;
         end
      end

      // length modifiers, anything else is the conversion
      if (!fin && nx.phase == fsp_pkg::PH_MOD) begin
         fin = 1'b1;
         if (ch inside {fsp_pkg::CH_LO_H, fsp_pkg::CH_LO_L, fsp_pkg::CH_LO_J, fsp_pkg::CH_LO_T,
                        fsp_pkg::CH_LO_Z, fsp_pkg::CH_LO_Q, fsp_pkg::CH_UP_L}) begin
            if (nx.mod_cnt >= fsp_pkg::MAX_MODS) begin
               res = fsp_pkg::RES_ERR;
            end else begin
               nx.mods[nx.mod_cnt] = ch;
               nx.mod_cnt          = nx.mod_cnt + 2'd1;
            end
         end else begin
            res = fsp_pkg::RES_DONE;
         end
      end
   end

   assign emit = live && (res != fsp_pkg::RES_MORE);

   always_comb begin
      st_next = st;
      if (live) begin
         st_next = nx;
         if (res != fsp_pkg::RES_MORE) st_next.phase = fsp_pkg::PH_IDLE;
      end
   end

   always_comb begin
      result = '0;
      if (res == fsp_pkg::RES_ERR) begin
         result.status = 1'b1;
      end else begin
         result.marks           = nx.marks;
         result.separator       = nx.sep;
         result.width_value     = nx.width_val;
         result.precision_value = nx.prec_val;
         result.value_index     = nx.vidx;
         result.width_index     = nx.widx;
         result.precision_index = nx.pidx;
         result.modifiers       = nx.mods;
         result.conversion      = ch;
         result.spec_length     = nx.position + 7'd1;
         result.arg_next        = {1'b0, nx.arg_cnt} + 9'd1;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fsp_out_reg.sv
`default_nettype none

// result register, holds a result until the consumer takes it
module fsp_out_reg (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 load,
   input  wire  fsp_pkg::result_type  din,
   input  wire  logic                 rsp_ready,
   output logic                       rsp_valid,
   output logic                       free,
   output fsp_pkg::result_type        dout
);

   logic                valid_ff;
   logic                valid_in;
   fsp_pkg::result_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= din;
   end

   assign rsp_valid = valid_ff;
   assign dout      = data_ff;

endmodule

`default_nettype wire

>>> rtl/format_spec_parser.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_ch, req_first, req_arg_base
// rsp       out        rsp_valid/rsp_ready  rsp_status ... rsp_arg_next (12 fields)
// csr       in         csr_wr_en            csr_wr_data (boolean flag enable)
//
// one character per cycle: a transfer lands in the input register, and from there
// the parse step updates the spec state and, on the conversion character or an
// error, loads the result register that drives rsp.
// reset is synchronous, active high: parser at spec start, no result pending,
// boolean flag enabled. a result waiting on rsp_ready stalls only a character
// that itself ends a spec; characters that only advance the parse keep flowing.
`default_nettype none

`include "format_spec_parser_macros.svh"

module format_spec_parser (
   input  wire  logic        clock,
   input  wire  logic        reset,
   // input characters
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic [7:0]  req_ch,
   input  wire  logic        req_first,
   input  wire  logic [7:0]  req_arg_base,
   // parsed spec results
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic              rsp_status,
   output logic [13:0]       rsp_marks,
   output logic [7:0]        rsp_separator,
   output logic [15:0]       rsp_width_value,
   output logic [15:0]       rsp_precision_value,
   output logic [7:0]        rsp_value_index,
   output logic [7:0]        rsp_width_index,
   output logic [7:0]        rsp_precision_index,
   output logic [23:0]       rsp_modifiers,
   output logic [7:0]        rsp_conversion,
   output logic [6:0]        rsp_spec_length,
   output logic [8:0]        rsp_arg_next,
   // configuration
   input  wire  logic        csr_wr_en,
   input  wire  logic        csr_wr_data
);

   // input register
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          ch_ff;
   logic                first_ff;
   logic [7:0]          base_ff;

   // spec state
   fsp_pkg::state_type  state_ff;
   fsp_pkg::state_type  state_in;

   logic                bool_en_ff;
   logic                bool_en_in;

   fsp_pkg::result_type step_res;
   fsp_pkg::result_type out_res;
   logic                emit;
   logic                out_free;
   logic                adv;
   logic                req_xfer;

   // the held character goes through unless it ends a spec while the result
   // register is still occupied
   assign adv       = in_valid_ff && (!emit || out_free);
   assign req_ready = !in_valid_ff || adv;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in = req_xfer ? 1'b1 : (adv ? 1'b0 : in_valid_ff);
   assign bool_en_in  = csr_wr_en ? csr_wr_data : bool_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         bool_en_ff  <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         bool_en_ff  <= bool_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ch_ff    <= req_ch;
         first_ff <= req_first;
         base_ff  <= req_arg_base;
      end
   end

   // state only moves when the held character is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         // all-zero state is spec start (phase begin) with nothing parsed
         state_ff <= '0;
      end else if (adv) begin
         state_ff <= state_in;
      end
   end

   fsp_step u_step (
      .st       (state_ff),
      .ch       (ch_ff),
      .first    (first_ff),
      .arg_base (base_ff),
      .bool_en  (bool_en_ff),
      .st_next  (state_in),
      .emit     (emit),
      .result   (step_res)
   );

   fsp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (adv && emit),
      .din       (step_res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .free      (out_free),
      .dout      (out_res)
   );

   assign rsp_status          = out_res.status;
   assign rsp_marks           = out_res.marks;
   assign rsp_separator       = out_res.separator;
   assign rsp_width_value     = out_res.width_value;
   assign rsp_precision_value = out_res.precision_value;
   assign rsp_value_index     = out_res.value_index;
   assign rsp_width_index     = out_res.width_index;
   assign rsp_precision_index = out_res.precision_index;
   assign rsp_modifiers       = out_res.modifiers;
   assign rsp_conversion      = out_res.conversion;
   assign rsp_spec_length     = out_res.spec_length;
   assign rsp_arg_next        = out_res.arg_next;

   // an error result carries nothing but the status bit
   `FSP_ASSERT_NOW(a_err_clean, clock, reset, rsp_valid && rsp_status,
      rsp_marks == 14'd0 && rsp_conversion == 8'd0 && rsp_spec_length == 7'd0
      && rsp_arg_next == 9'd0, "error result with nonzero fields")

   // a complete spec has the percent sign and a conversion at least
   `FSP_ASSERT_NOW(a_done_len, clock, reset, rsp_valid && !rsp_status,
      rsp_spec_length >= 7'd2 && rsp_arg_next != 9'd0, "complete result too short")

   // a spec that produced a result leaves the parser idle
   `FSP_ASSERT_NEXT(a_idle_after, clock, reset, adv && emit,
      state_ff.phase == fsp_pkg::PH_IDLE, "parser not idle after result")

   // backpressure only from a held spec end facing a full result register
   `FSP_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready,
      in_valid_ff && emit && !out_free, "input stalled without cause")

endmodule

`default_nettype wire
